// File: sv/bffa_pkg.sv
// Shared types and codes for the first-fit bitmap allocator.
`default_nettype none
package bffa_pkg;

    localparam int LIMIT_W  = 14;
    localparam int INDEX_W  = 13;
    localparam int STATUS_W = 2;
    localparam int LIMIT_MAX = (2 ** LIMIT_W) - 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

    localparam int REG_ENTRY_LIMIT = 0;

    typedef struct packed {
        logic                strobe;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted;
    } t_result;

endpackage
`default_nettype wire

// File: sv/bffa_map_mem.sv
// Usage map storage: one write port, one read port, registered read data.
`default_nettype none
module bffa_map_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/bffa_div.sv
// Index splitter for a power-of-two word width: registers the word number and bit position.
`default_nettype none
module bffa_div import bffa_pkg::*; #(
    parameter int DIVISOR = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [INDEX_W-1:0]            i_dividend,
    output logic                               o_done,
    output logic      [INDEX_W-1:0]            o_quot,
    output logic      [$clog2(DIVISOR)-1:0]    o_rem
);

    localparam int RW = $clog2(DIVISOR);

    logic               r_done;
    logic [INDEX_W-1:0] r_q;
    logic [RW-1:0]      r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // shift off the bit position for the word number, keep the low bits as the position
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend >> RW;
            r_rem <= i_dividend[RW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(i_start))
        else $error("split done without a start");

endmodule
`default_nettype wire

// File: sv/bffa_engine.sv
// Allocator sequencer: clear pass, first-fit word scan and read-modify-write of the map.
`default_nettype none
module bffa_engine import bffa_pkg::*; #(
    parameter int MAP_ENTRIES   = 8192,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_opcode,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    input  wire logic [LIMIT_W-1:0] i_limit,
    output logic                    o_busy,
    output t_result                 o_result
);

    localparam int MAP_WORDS = (MAP_ENTRIES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BP_W      = $clog2(MAP_WORD_BITS);

    localparam logic [WA_W-1:0]          LAST_WORD = WA_W'(MAP_WORDS - 1);
    localparam logic [MAP_WORD_BITS-1:0] WORD_ONE  = MAP_WORD_BITS'(1);
    localparam logic [LIMIT_W-1:0]       WORD_SPAN = LIMIT_W'(MAP_WORD_BITS);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_FREE_WB = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [WA_W-1:0]    r_addr,  n_addr;
    logic [BP_W-1:0]    r_pos,   n_pos;
    logic [LIMIT_W-1:0] r_rem,   n_rem;
    logic [LIMIT_W-1:0] r_base,  n_base;
    logic               r_op,    n_op;
    logic [LIMIT_W-1:0] r_lim,   n_lim;
    t_result            r_result, n_result;

    logic                     mem_we;
    logic [WA_W-1:0]          mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [WA_W-1:0]          mem_raddr;
    logic [MAP_WORD_BITS-1:0] mem_rdata;

    logic                     div_start;
    logic                     div_done;
    logic [INDEX_W-1:0]       div_quot;
    logic [BP_W-1:0]          div_rem;

    logic [MAP_WORD_BITS-1:0] avail;
    logic                     hit;
    logic [BP_W-1:0]          hit_pos;
    logic                     last_word;

    bffa_map_mem #(
        .DEPTH (MAP_WORDS),
        .WIDTH (MAP_WORD_BITS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bffa_div #(
        .DIVISOR (MAP_WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_entry_index),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // free bits of the current word that lie below the limit, lowest first
    always_comb begin
        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            avail[j] = !mem_rdata[j] && (r_rem > LIMIT_W'(j));
        end
        hit     = 1'b0;
        hit_pos = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
            if (avail[j]) begin
                hit     = 1'b1;
                hit_pos = BP_W'(j);
            end
        end
        last_word = r_rem <= WORD_SPAN;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_base    = r_base;
        n_op      = r_op;
        n_lim     = r_lim;
        n_result  = '0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_raddr = r_addr;
        div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == LAST_WORD) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_opcode;
                    n_lim = i_limit;
                    if (i_opcode == OP_ALLOC) begin
                        if (i_limit == '0) begin
                            n_result.strobe = 1'b1;
                            n_result.status = ST_NONE_FREE;
                        end else begin
                            mem_raddr = '0;
                            n_addr    = '0;
                            n_rem     = i_limit;
                            n_base    = '0;
                            n_state   = S_SCAN;
                        end
                    end else if ({1'b0, i_entry_index} >= i_limit) begin
                        n_result.strobe = 1'b1;
                        n_result.status = ST_RANGE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    mem_raddr = WA_W'(div_quot);
                    n_addr    = WA_W'(div_quot);
                    n_pos     = div_rem;
                    n_state   = S_FREE_WB;
                end
            end
            S_FREE_WB: begin
                mem_we          = 1'b1;
                mem_wdata       = mem_rdata & ~(WORD_ONE << r_pos);
                n_result.strobe = 1'b1;
                n_result.status = ST_OK;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (hit) begin
                    mem_we           = 1'b1;
                    mem_wdata        = mem_rdata | (WORD_ONE << hit_pos);
                    n_result.strobe  = 1'b1;
                    n_result.status  = ST_OK;
                    n_result.granted = INDEX_W'(r_base + LIMIT_W'(hit_pos));
                    n_state          = S_IDLE;
                end else if (last_word) begin
                    n_result.strobe = 1'b1;
                    n_result.status = ST_NONE_FREE;
                    n_state         = S_IDLE;
                end else begin
                    mem_raddr = r_addr + 1'b1;
                    n_addr    = r_addr + 1'b1;
                    n_rem     = r_rem - WORD_SPAN;
                    n_base    = r_base + WORD_SPAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_op   <= n_op;
        r_lim  <= n_lim;
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_result = r_result;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !r_result.strobe)
        else $error("result issued during clearing pass");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_SCAN || r_state == S_FREE_WB))
        else $error("map written outside a write state");

    a_grant_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result.strobe && r_result.status == ST_OK && r_op == OP_ALLOC)
            |-> ({1'b0, r_result.granted} < r_lim))
        else $error("granted index at or above the limit");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside a free request");

    a_scan_has_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_rem != '0)
        else $error("scan running with no entries left");

endmodule
`default_nettype wire

// File: sv/bitmap_first_free_allocator.sv
// Top level of the first-fit bitmap allocator: APB register, engine, result ports.
// Allocate: reads the map words in order from word 0 and answers with the lowest free entry
//   below the limit, or with none free once the word that holds the limit is passed.
// Free in range: split the index, read the map word, write it back. Out-of-range free and
//   allocate with a zero limit answer straight from idle. One request at a time; busy drops
//   with o_done, so the next request is taken at the edge that ends the o_done cycle.
// Reset: synchronous; a clearing pass zeroes the map's MAP_WORDS words (128 by default)
//   with busy high; o_done is a single-cycle strobe that the receiver cannot stall.
`default_nettype none
module bitmap_first_free_allocator import bffa_pkg::*; #(
    parameter int MAP_ENTRIES   = 8192,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request side
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_opcode,
    input  wire logic [INDEX_W-1:0]  i_entry_index,
    // result side
    output logic                     o_done,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [INDEX_W-1:0]  o_granted_index,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    // Largest limit that means anything: the map size, or the register's range.
    localparam int LIM_CAP = (MAP_ENTRIES > LIMIT_MAX) ? LIMIT_MAX : MAP_ENTRIES;
    localparam logic [LIMIT_W-1:0] LIM_CAP_V = LIMIT_W'(LIM_CAP);

    logic [LIMIT_W-1:0] r_entry_limit;
    logic [LIMIT_W-1:0] active_limit;
    logic               reg_write;
    logic               sel_limit;
    t_result            result;

    // Registers sit on word boundaries; bit 2 picks the register.
    assign sel_limit = paddr[2] == 1'(REG_ENTRY_LIMIT);
    assign reg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= LIMIT_RESET;
        end else if (reg_write && sel_limit) begin
            r_entry_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Drop writes to unmapped addresses, read back zero there.
    always_comb begin
        prdata = '0;
        if (sel_limit) begin
            prdata = {{(32 - LIMIT_W){1'b0}}, r_entry_limit};
        end
    end

    // Clamp a limit above the map size to the map size.
    assign active_limit = (r_entry_limit > LIM_CAP_V) ? LIM_CAP_V : r_entry_limit;

    bffa_engine #(
        .MAP_ENTRIES   (MAP_ENTRIES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_limit       (active_limit),
        .o_busy        (busy),
        .o_result      (result)
    );

    // Result fields come straight off the engine's result register.
    assign o_done          = result.strobe;
    assign o_status        = result.status;
    assign o_granted_index = result.granted;

endmodule
`default_nettype wire

// File: verif/bitmap_first_free_allocator_test.sv
// Self-checking testbench for the first-fit bitmap allocator: directed cases, then random traffic.
`timescale 1ns / 100ps

import bffa_pkg::*;

localparam logic [2:0] ADDR_LIMIT = 3'(REG_ENTRY_LIMIT * 4);
localparam logic [2:0] ADDR_SPARE = ADDR_LIMIT + 3'd4;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted;
} t_grant;

class alloc_scoreboard;
    localparam int MAP_SIZE = 8192;

    bit [MAP_SIZE-1:0]  in_use   = '0;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    t_grant             expected_grants[$];
    int                 errors   = 0;

    function void write_register(input logic [2:0] addr, input logic [31:0] data);
        if (addr == ADDR_LIMIT)
            limit_reg = data[LIMIT_W-1:0];
    endfunction

    // Work out the answer to one accepted request and queue it.
    function void note_request(input logic op, input logic [INDEX_W-1:0] idx,
                               output t_grant ans);
        int lim;
        int i;
        bit found;
        lim = (int'(limit_reg) > MAP_SIZE) ? MAP_SIZE : int'(limit_reg);
        ans.status  = ST_OK;
        ans.granted = '0;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            for (i = 0; i < lim && !found; i++) begin
                if (!in_use[i]) begin
                    in_use[i]   = 1'b1;
                    ans.granted = INDEX_W'(i);
                    found       = 1'b1;
                end
            end
            if (!found)
                ans.status = ST_NONE_FREE;
        end else if (int'(idx) >= lim) begin
            ans.status = ST_RANGE;
        end else begin
            in_use[idx] = 1'b0;
        end
        expected_grants.push_back(ans);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] status,
                               input logic [INDEX_W-1:0] granted);
        t_grant exp_ans;
        if (expected_grants.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d index %0d",
                     $time, status, granted);
            errors++;
        end else begin
            exp_ans = expected_grants.pop_front();
            if (status !== exp_ans.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp_ans.status, status);
                errors++;
            end
            if (granted !== exp_ans.granted) begin
                $display("%0t: granted index mismatch: expected %0d, actual %0d",
                         $time, exp_ans.granted, granted);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_grants.size();
    endfunction
endclass

module bitmap_first_free_allocator_test;

    // Allow the slowest legal run several times over: ~620 requests at the longest
    // engine scan plus sender gaps, the reset clearing pass and config.
    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                i_opcode      = OP_ALLOC;
    logic [INDEX_W-1:0]  i_entry_index = '0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic                busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_granted_index;
    logic [31:0]         prdata;
    logic                pready;

    alloc_scoreboard sb;
    int              cycles = 0;
    // Indices the allocator has handed out and the test has not yet freed.
    int              held[$];

    bitmap_first_free_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_entry_index  (i_entry_index),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result monitor and watchdog. The receiver cannot stall, so take every
    // strobe as it comes and compare it with the oldest expectation.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n && o_done) begin
            sb.check_result(o_status, o_granted_index);
        end
    end

    // Present one request at the falling edge and hold it until the rising
    // edge that sees busy low; that edge accepts it.
    task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx);
        t_grant ans;
        @(negedge i_clk);
        start         <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(op, idx, ans);
        if (op == OP_ALLOC && ans.status == ST_OK)
            held.push_back(int'(ans.granted));
    endtask

    // Drop start and scramble the payload; n sets how long the sender stays idle.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_opcode      <= 1'($urandom);
            i_entry_index <= INDEX_W'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding request has answered and
    // the engine has gone back to idle.
    task automatic wait_quiet();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
        wait_quiet();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_register(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
    endtask

    // Random traffic: about half allocations, most frees return an index
    // that is actually held, the rest hit random or near-limit indices.
    task automatic run_phase(input int n, input int idle_pct, input int max_gap);
        int k;
        int pick;
        int span;
        logic [INDEX_W-1:0] idx;
        for (k = 0; k < n; k++) begin
            if (max_gap > 0 && $urandom_range(99) < idle_pct)
                idle_cycles($urandom_range(1, max_gap));
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_request(OP_ALLOC, INDEX_W'($urandom));
            end else if (pick < 85 && held.size() > 0) begin
                pick = $urandom_range(0, held.size() - 1);
                idx  = INDEX_W'(held[pick]);
                held.delete(pick);
                send_request(OP_FREE, idx);
            end else begin
                span = 2 * int'(sb.limit_reg) + 1;
                if (span > 8191)
                    span = 8191;
                if ($urandom_range(1))
                    idx = INDEX_W'($urandom);
                else
                    idx = INDEX_W'($urandom_range(0, span));
                send_request(OP_FREE, idx);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default limit, first-fit order, free of a free entry.
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 13'd1);
        send_request(OP_FREE, 13'd1);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '1);
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, 13'h0AAA);

        // Limit above the map size acts as the map size.
        set_register(ADDR_LIMIT, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 13'h1555);
        send_request(OP_FREE, '1);

        // Tiny limit: map full, frees at and above the limit.
        set_register(ADDR_LIMIT, 32'd4);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, 13'd4);
        send_request(OP_FREE, '1);
        send_request(OP_FREE, 13'd3);
        send_request(OP_ALLOC, '0);

        // Zero limit: nothing to allocate, every free out of range.
        set_register(ADDR_LIMIT, 32'd0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        // Write to a register that does not exist; the limit must stay zero.
        set_register(ADDR_SPARE, 32'd100);
        send_request(OP_ALLOC, '0);

        // Limit of one entry.
        set_register(ADDR_LIMIT, 32'd1);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);

        // Random phases over several limits and idle patterns.
        held.delete();
        set_register(ADDR_LIMIT, 32'd40);
        run_phase(150, 0, 0);

        set_register(ADDR_LIMIT, 32'h0000_3FFF);
        run_phase(75, 64, 6);
        wait_quiet();
        run_phase(75, 64, 6);

        set_register(ADDR_LIMIT, 32'd1);
        run_phase(60, 28, 3);

        set_register(ADDR_LIMIT, 32'd200);
        run_phase(150, 28, 3);

        set_register(ADDR_LIMIT, 32'($urandom_range(2, 64)));
        run_phase(90, 64, 4);

        // Drain, then leave room for the longest scan before judging.
        wait_quiet();
        repeat (140) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
